// ----- design/tss_pkg.sv -----
// Shared constants and types for the text sanitizer stream block.
// No dependencies; imported by text_sanitizer_stream_unit and its testbench.
package tss_pkg;

  localparam logic [7:0] CharsetExt = 8'h10;
  localparam logic [7:0] CharsetMax = 8'h1F;
  localparam logic [7:0] Byte8A     = 8'h8A;
  localparam logic [7:0] ByteLf     = 8'h0A;
  localparam logic [7:0] ByteCr     = 8'h0D;
  localparam logic [7:0] ByteAmp    = 8'h26;
  localparam logic [7:0] ByteUnder  = 8'h5F;
  localparam logic [7:0] ByteDash   = 8'h2D;
  localparam logic [7:0] ByteQuote  = 8'h22;
  localparam logic [7:0] ByteBslash = 8'h5C;
  localparam logic [7:0] ByteA      = 8'h61;
  localparam logic [7:0] ByteM      = 8'h6D;
  localparam logic [7:0] ByteP      = 8'h70;
  localparam logic [7:0] ByteSemi   = 8'h3B;

  localparam int unsigned MaxResults = 5;

  localparam logic [7:0] RegMaxLength = 8'd0;
  localparam logic [7:0] RegFilter    = 8'd1;

  localparam int unsigned FlagCrlf  = 0;
  localparam int unsigned FlagMap8a = 1;
  localparam int unsigned FlagQuote = 2;

  typedef logic [MaxResults-1:0][7:0] res_buf_t;
  typedef logic [2:0] res_cnt_t;

endpackage

// ----- design/text_sanitizer_stream_unit.sv -----
// Text sanitizer stream: top level with byte rewrite and result buffer.
// Depends on tss_pkg for byte codes and buffer types.
//
// Usage:
// Bytes of a zero-terminated string enter on the s_axis channel, one beat
// per byte (tdata[7:0] = in_byte). Results leave on the m_axis channel:
// tdata[7:0] = out_byte, tlast = last result of one input byte, tuser[0] =
// end_of_string (set on the terminating zero). A leading charset code is
// dropped, '&' expands to "&amp;", and the configured filters apply.
// Registers are written on the cfg channel (index 0 max_length, index 1
// filter_flags); cfg_ready_o is always high. The user must make writes
// only while the block is idle; the block itself does not enforce this.
// An accepted byte's first result is offered the next cycle. With the
// receiver ready, a one-result byte sustains one byte per cycle; a byte
// with more results holds the input while the single result buffer shifts
// out one beat per cycle. The next byte is taken in the cycle the last
// pending result leaves; bytes with no result are taken every cycle when
// idle. When the receiver stalls, the pending result holds and the input
// is not ready once the buffer cannot drain. Reset empties the buffer,
// sets max_length to 255, clears filter_flags and starts a new string.
module text_sanitizer_stream_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic        m_axis_tlast,   // last_of_run
  output logic [0:0]  m_axis_tuser,   // [0] end_of_string
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import tss_pkg::*;

  logic [15:0] max_len_q;
  logic [2:0]  flags_q;
  logic        at_start_q, at_start_d;
  logic [1:0]  skip_q, skip_d;
  logic [16:0] count_q, count_d;
  logic        limit_q, limit_d;
  res_buf_t    buf_q, buf_d;
  res_cnt_t    rem_q, rem_d;
  logic        eos_q, eos_d;

  res_buf_t    new_buf;
  res_cnt_t    new_n;
  logic        new_eos;
  logic        in_acc, out_acc;
  logic [7:0]  b;

  assign b             = s_axis_tdata;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = (rem_q != 3'd0);
  assign m_axis_tdata  = buf_q[0];
  assign m_axis_tlast  = (rem_q == 3'd1);
  assign m_axis_tuser  = eos_q;
  assign out_acc       = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (rem_q == 3'd0) || (out_acc && rem_q == 3'd1);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    new_buf    = '0;
    new_n      = 3'd0;
    new_eos    = 1'b0;
    at_start_d = at_start_q;
    skip_d     = skip_q;
    count_d    = count_q;
    limit_d    = limit_q;
    if (b == 8'h00) begin
      new_n      = 3'd1;
      new_eos    = 1'b1;
      at_start_d = 1'b1;
      skip_d     = 2'd0;
      count_d    = '0;
      limit_d    = 1'b0;
    end else if (at_start_q && b <= CharsetMax) begin
      at_start_d = 1'b0;
      skip_d     = (b == CharsetExt) ? 2'd2 : 2'd0;
    end else if (!at_start_q && skip_q != 2'd0) begin
      skip_d = skip_q - 2'd1;
    end else begin
      at_start_d = 1'b0;
      if (!limit_q) begin
        case (b)
          ByteAmp: begin
            new_buf = {ByteSemi, ByteP, ByteM, ByteA, ByteAmp};
            new_n   = 3'd5;
          end
          ByteUnder: begin
            new_buf[0] = ByteDash;
            new_n      = 3'd1;
          end
          ByteCr, ByteLf: begin
            new_buf[0] = b;
            new_n      = flags_q[FlagCrlf] ? 3'd0 : 3'd1;
          end
          Byte8A: begin
            new_buf[0] = flags_q[FlagMap8a] ? ByteLf : b;
            new_n      = 3'd1;
          end
          ByteQuote: begin
            if (flags_q[FlagQuote]) begin
              new_buf[0] = ByteBslash;
              new_buf[1] = ByteQuote;
              new_n      = 3'd2;
            end else begin
              new_buf[0] = ByteQuote;
              new_n      = 3'd1;
            end
          end
          default: begin
            new_buf[0] = b;
            new_n      = 3'd1;
          end
        endcase
        count_d = count_q + {14'd0, new_n};
        limit_d = (count_d >= {1'b0, max_len_q});
      end
    end
  end

  always_comb begin
    buf_d = buf_q;
    rem_d = rem_q;
    eos_d = eos_q;
    if (out_acc) begin
      buf_d = {8'h00, buf_q[MaxResults-1:1]};
      rem_d = rem_q - 3'd1;
    end
    if (in_acc && new_n != 3'd0) begin
      buf_d = new_buf;
      rem_d = new_n;
      eos_d = new_eos;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q  <= 16'd255;
      flags_q    <= 3'd0;
      at_start_q <= 1'b1;
      skip_q     <= 2'd0;
      count_q    <= '0;
      limit_q    <= 1'b0;
      rem_q      <= 3'd0;
    end else begin
      if (cfg_valid_i && cfg_index_i == RegMaxLength) begin
        max_len_q <= cfg_data_i;
      end
      if (cfg_valid_i && cfg_index_i == RegFilter) begin
        flags_q <= cfg_data_i[2:0];
      end
      if (in_acc) begin
        at_start_q <= at_start_d;
        skip_q     <= skip_d;
        count_q    <= count_d;
        limit_q    <= limit_d;
      end
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
    eos_q <= eos_d;
  end

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q <= 3'd5) else $error("result buffer count out of range");

  a_eos_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
    else $error("terminating zero not marked last");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> (rem_q == 3'd0 || (out_acc && rem_q == 3'd1)))
    else $error("byte accepted while results pending");

  a_limit_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    limit_q |-> !at_start_q) else $error("limit set at string start");

endmodule

// ----- verif/text_sanitizer_stream_unit_tb.sv -----
// Testbench for text_sanitizer_stream_unit: directed and random byte strings,
// checked beat by beat against a predictor of the sanitizer kept in this file.
// Depends on tss_pkg and the design under design/.
module text_sanitizer_stream_unit_tb;
  import tss_pkg::*;

  localparam logic [7:0] RegUnused    = 8'd2;
  localparam logic [7:0] RegUnusedTop = 8'hFF;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       end_of_string;
  } sanitized_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;
  logic [0:0]  m_axis_tuser;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_index_i   = 8'h00;
  logic [15:0] cfg_data_i    = 16'h0000;

  sanitized_t  sanitized_q[$];
  int          fail_count    = 0;
  int          sent_items    = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_left     = 0;

  logic        m_at_start    = 1'b1;
  logic [1:0]  m_skip_left   = 2'd0;
  logic [16:0] m_out_count   = 17'd0;
  logic        m_limit_hit   = 1'b0;
  logic [15:0] m_max_len     = 16'd255;
  logic [2:0]  m_flags       = 3'd0;

  text_sanitizer_stream_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic void sanitize_byte(input logic [7:0] b);
    logic [7:0] outs [MaxResults];
    sanitized_t r;
    int n;
    n = 0;
    if (b == 8'h00) begin
      r.out_byte      = 8'h00;
      r.last_of_run   = 1'b1;
      r.end_of_string = 1'b1;
      sanitized_q.push_back(r);
      m_at_start  = 1'b1;
      m_skip_left = 2'd0;
      m_out_count = 17'd0;
      m_limit_hit = 1'b0;
      return;
    end
    if (m_at_start) begin
      m_at_start = 1'b0;
      if (b <= CharsetMax) begin
        m_skip_left = (b == CharsetExt) ? 2'd2 : 2'd0;
        return;
      end
    end else if (m_skip_left != 2'd0) begin
      m_skip_left = m_skip_left - 2'd1;
      return;
    end
    if (m_limit_hit) return;
    case (b)
      ByteAmp: begin
        outs[0] = ByteAmp;
        outs[1] = ByteA;
        outs[2] = ByteM;
        outs[3] = ByteP;
        outs[4] = ByteSemi;
        n = 5;
      end
      ByteUnder: begin
        outs[0] = ByteDash;
        n = 1;
      end
      ByteCr, ByteLf: begin
        if (!m_flags[FlagCrlf]) begin
          outs[0] = b;
          n = 1;
        end
      end
      Byte8A: begin
        outs[0] = m_flags[FlagMap8a] ? ByteLf : b;
        n = 1;
      end
      ByteQuote: begin
        if (m_flags[FlagQuote]) begin
          outs[n] = ByteBslash;
          n = n + 1;
        end
        outs[n] = b;
        n = n + 1;
      end
      default: begin
        outs[0] = b;
        n = 1;
      end
    endcase
    m_out_count = m_out_count + 17'(n);
    if (m_out_count >= {1'b0, m_max_len}) m_limit_hit = 1'b1;
    for (int i = 0; i < n; i++) begin
      r.out_byte      = outs[i];
      r.last_of_run   = (i == n - 1);
      r.end_of_string = 1'b0;
      sanitized_q.push_back(r);
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) sanitize_byte(s_axis_tdata);
  end

  always @(posedge clk_i) begin
    sanitized_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (sanitized_q.size() == 0) begin
        $error("unexpected beat: out_byte %h", m_axis_tdata);
        fail_count++;
      end else begin
        e = sanitized_q.pop_front();
        if (m_axis_tdata !== e.out_byte) begin
          $error("out_byte: expected %h, got %h", e.out_byte, m_axis_tdata);
          fail_count++;
        end
        if (m_axis_tlast !== e.last_of_run) begin
          $error("last_of_run: expected %b, got %b", e.last_of_run, m_axis_tlast);
          fail_count++;
        end
        if (m_axis_tuser[0] !== e.end_of_string) begin
          $error("end_of_string: expected %b, got %b", e.end_of_string, m_axis_tuser[0]);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    sent_items++;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic send_seq(input logic [7:0] seq[$]);
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  task automatic stop_sending();
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic wait_idle(input int settle);
    @(posedge clk_i);
    while (sanitized_q.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    if (idx == RegMaxLength) m_max_len = data;
    else if (idx == RegFilter) m_flags = data[2:0];
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_text_byte();
    case ($urandom_range(9))
      0: return ByteAmp;
      1: return ByteUnder;
      2: return ByteCr;
      3: return ByteLf;
      4: return Byte8A;
      5: return ByteQuote;
      6: return 8'($urandom_range(1, 31));
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  function automatic logic [7:0] pick_skip_byte();
    if ($urandom_range(15) == 0) return 8'h00;
    return 8'($urandom_range(1, 255));
  endfunction

  function automatic logic [15:0] pick_max_length();
    case ($urandom_range(5))
      0: return 16'd1;
      1: return 16'($urandom_range(2, 6));
      2: return 16'($urandom_range(7, 20));
      3: return 16'hFFFF;
      4: return 16'd255;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic send_random_string();
    int len;
    if ($urandom_range(9) == 0) begin
      len = $urandom_range(1, 8);
      repeat (len) send_byte(8'($urandom_range(255)));
      return;
    end
    case ($urandom_range(3))
      1: send_byte(8'($urandom_range(1, 31)));
      2: begin
        send_byte(CharsetExt);
        send_byte(pick_skip_byte());
        send_byte(pick_skip_byte());
      end
      default: ;
    endcase
    len = $urandom_range(0, 10);
    repeat (len) send_byte(pick_text_byte());
    send_byte(8'h00);
  endtask

  task automatic test_defaults();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_seq('{8'h00});
    send_seq('{8'h01, 8'h41, ByteCr, ByteLf, Byte8A, ByteQuote, 8'h00});
    stop_sending();
    wait_idle(4);
  endtask

  task automatic test_filters_and_header();
    write_reg(RegMaxLength, 16'hFFFF);
    write_reg(RegFilter, 16'hFFFF);
    send_seq('{CharsetExt, 8'h80, 8'h7F, ByteAmp, ByteUnder, ByteCr, ByteLf,
               Byte8A, ByteQuote, 8'hFF, 8'h00});
    // Terminator inside the header skip, then straight after a short header.
    send_seq('{CharsetExt, 8'h00});
    send_seq('{8'h05, 8'h00});
    stop_sending();
    wait_idle(4);
  endtask

  task automatic test_limit();
    write_reg(RegMaxLength, 16'd0);
    write_reg(RegFilter, 16'd0);
    send_seq('{CharsetMax, ByteAmp, 8'h78, 8'h00});
    stop_sending();
    wait_idle(4);
    write_reg(RegMaxLength, 16'd3);
    send_seq('{8'h41, ByteAmp, 8'h62, 8'h00});
    stop_sending();
    wait_idle(4);
    write_reg(RegMaxLength, 16'd1);
    write_reg(RegUnused, 16'hFFFF);
    write_reg(RegUnusedTop, 16'hFFFF);
    send_seq('{8'h42, 8'h43, 8'h00});
    stop_sending();
    wait_idle(4);
  endtask

  task automatic test_random_strings(input int s_pct, input int r_pct, input int n_items);
    int target;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    target = sent_items + n_items;
    while (sent_items < target) begin
      if ($urandom_range(3) == 0) begin
        stop_sending();
        wait_idle(4);
        write_reg(RegMaxLength, pick_max_length());
        write_reg(RegFilter, 16'($urandom_range(0, 65535)));
      end
      send_random_string();
    end
    stop_sending();
    wait_idle(4);
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(RegMaxLength, 16'hFFFF);
    write_reg(RegFilter, 16'd7);
    hold_left = 200;
    repeat (8) send_byte(ByteAmp);
    send_seq('{ByteQuote, 8'h41, 8'h00});
    stop_sending();
    wait_idle(10);
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_defaults();
    test_filters_and_header();
    test_limit();
    test_random_strings(31, 74, 25);
    test_random_strings(74, 31, 25);
    test_random_strings(0, 0, 25);
    test_backpressure();
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule

// ----- sim.f -----
design/tss_pkg.sv
design/text_sanitizer_stream_unit.sv
verif/text_sanitizer_stream_unit_tb.sv
